### hw/rtl/vector_align_rotation_3d_assert.svh
// ----------------------------------------------------------------------------
// vector_align_rotation_3d assertion macros
// clocked property helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef VECTOR_ALIGN_ROTATION_3D_ASSERT_SVH
`define VECTOR_ALIGN_ROTATION_3D_ASSERT_SVH

// consequent must hold in the same cycle
`define VARA_CHECK(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define VARA_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vara_pkg.sv
// ----------------------------------------------------------------------------
// vara_pkg
// types, constants and rounding helpers for the vector alignment rotation
// ----------------------------------------------------------------------------
package vara_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int QW        = FRAC_BITS + 1;       // root digits, one per cell
    localparam int RSH       = 2 * FRAC_BITS + 2;   // scale of the root numerator
    localparam int SQW       = 32;                  // square and sum width
    localparam int DW        = 68;                  // remainder width
    localparam int ACW       = 48;                  // den * q accumulator width
    localparam int LANES     = 4;
    localparam int ENT_W     = 16;
    localparam int VEC_W     = 17;
    localparam int VEC_MAX   = 65535;
    localparam int VEC_MIN   = -65536;

    // lane order in the root chain
    localparam int L_CPHI = 0;
    localparam int L_SPHI = 1;
    localparam int L_CTH  = 2;
    localparam int L_STH  = 3;

    typedef struct packed {
        logic signed [DW-1:0] rem;
        logic [ACW-1:0]       acc;
        logic [QW-1:0]        q;
    } root_lane_t;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] a;
        logic signed [IN_WIDTH-1:0] b;
        logic signed [IN_WIDTH-1:0] c;
        logic [SQW-1:0]             s1;
        logic [SQW-1:0]             s;
        root_lane_t [LANES-1:0]     lane;
    } chain_t;

    // shift right with rounding to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                      input int sh);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [ENT_W-1:0] clamp_ent(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > 64'(ONE)) r = 64'(ONE);
        if (v < -64'(ONE)) r = -64'(ONE);
        return ENT_W'(r);
    endfunction

    function automatic logic signed [VEC_W-1:0] clamp_vec(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > 64'(VEC_MAX)) r = 64'(VEC_MAX);
        if (v < 64'(VEC_MIN)) r = 64'(VEC_MIN);
        return VEC_W'(r);
    endfunction

endpackage

### hw/rtl/vector_align_rotation_3d.sv
// Pipeline: 2 entry stages, 15 root cells and 5 matrix stages from input transfer
// to result, each of them registered; full stages hold while the output stalls.
// Throughput: one vector per cycle while the output does not stall, set by the
// 15-cell root chain where each cell resolves one digit of all four ratios.
// Reset: aresetn low clears every stage valid; no result is held after reset.
// ----------------------------------------------------------------------------
// vector_align_rotation_3d
// rotation matrix that clears the first component of a 3-vector
// ----------------------------------------------------------------------------
module vector_align_rotation_3d (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // comp_a, comp_b, comp_c
    output logic         m_tvalid,
    input  logic         m_tready,
    // rot_11, rot_12, rot_13, rot_21, rot_22, rot_23_32, rot_31, rot_33,
    // out_a, out_b, out_c, zero fill
    output logic [183:0] m_tdata,
    output logic [0:0]   m_tuser    // degenerate
);
    import vara_pkg::*;

    logic [1:0] ev_reg;
    logic [1:0] erdy;

    logic signed [IN_WIDTH-1:0] a0_reg, b0_reg, c0_reg;
    logic [SQW-1:0]             aa_reg, bb_reg, cc_reg;
    chain_t                     init_reg;
    chain_t                     init_next;

    logic   [QW:0] ch_valid;
    logic   [QW:0] ch_ready;
    chain_t        ch_data [QW+1];

    logic signed [8:0][ENT_W-1:0] rot;
    logic signed [2:0][VEC_W-1:0] vec;
    logic                         deg;

    // entry stall chain
    assign erdy[1] = !ev_reg[1] || ch_ready[0];
    assign erdy[0] = !ev_reg[0] || erdy[1];
    assign s_tready = erdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_reg <= '0;
        end else begin
            if (erdy[0]) ev_reg[0] <= s_tvalid;
            if (erdy[1]) ev_reg[1] <= ev_reg[0];
        end
    end

    // entry stage: squares of the components
    always_ff @(posedge aclk) begin
        if (s_tvalid && erdy[0]) begin
            a0_reg <= s_tdata[15:0];
            b0_reg <= s_tdata[31:16];
            c0_reg <= s_tdata[47:32];
            aa_reg <= SQW'(32'($signed(s_tdata[15:0]))  * 32'($signed(s_tdata[15:0])));
            bb_reg <= SQW'(32'($signed(s_tdata[31:16])) * 32'($signed(s_tdata[31:16])));
            cc_reg <= SQW'(32'($signed(s_tdata[47:32])) * 32'($signed(s_tdata[47:32])));
        end
    end

    // norms and starting remainders of the four root lanes
    always_comb begin
        logic [SQW-1:0] s1;
        logic [SQW-1:0] s;
        s1 = bb_reg + cc_reg;
        s  = s1 + aa_reg;
        init_next.a  = a0_reg;
        init_next.b  = b0_reg;
        init_next.c  = c0_reg;
        init_next.s1 = s1;
        init_next.s  = s;
        init_next.lane[L_CPHI].rem = (DW'(cc_reg) <<< RSH) - DW'(s1);
        init_next.lane[L_SPHI].rem = (DW'(bb_reg) <<< RSH) - DW'(s1);
        init_next.lane[L_CTH].rem  = (DW'(s1) <<< RSH) - DW'(s);
        init_next.lane[L_STH].rem  = (DW'(aa_reg) <<< RSH) - DW'(s);
        for (int l = 0; l < LANES; l++) begin
            init_next.lane[l].acc = '0;
            init_next.lane[l].q   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_reg[0] && erdy[1]) begin
            init_reg <= init_next;
        end
    end

    assign ch_valid[0] = ev_reg[1];
    assign ch_data[0]  = init_reg;

    // root chain, most significant digit first
    for (genvar i = 0; i < QW; i++) begin : g_cell
        vara_cell #(
            .K (FRAC_BITS - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (ch_valid[i]),
            .in_ready  (ch_ready[i]),
            .in_data   (ch_data[i]),
            .out_valid (ch_valid[i+1]),
            .out_ready (ch_ready[i+1]),
            .out_data  (ch_data[i+1])
        );
    end

    vara_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ch_valid[QW]),
        .in_ready  (ch_ready[QW]),
        .in_data   (ch_data[QW]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rot   (rot),
        .out_vec   (vec),
        .out_deg   (deg)
    );

    // result packing
    assign m_tdata = {5'b0, vec[2], vec[1], vec[0], rot[8], rot[6], rot[5], rot[4],
                      rot[3], rot[2], rot[1], rot[0]};
    assign m_tuser = deg;

endmodule

### hw/rtl/vara_cell.sv
// ----------------------------------------------------------------------------
// vara_cell
// one digit of the rounded root ratio for all four lanes, registered
// ----------------------------------------------------------------------------
module vara_cell #(
    parameter int K = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  vara_pkg::chain_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output vara_pkg::chain_t out_data
);
    import vara_pkg::*;

    logic   valid_reg;
    chain_t data_reg;
    chain_t data_next;

    // trial digit: keep it when the remainder stays non-negative
    always_comb begin
        logic signed [DW-1:0] den_w;
        logic signed [DW-1:0] delta;
        logic signed [DW-1:0] trial;
        data_next = in_data;
        for (int l = 0; l < LANES; l++) begin
            den_w = (l < 2) ? DW'(in_data.s1) : DW'(in_data.s);
            delta = ((DW'(in_data.lane[l].acc) <<< 1) + (den_w <<< K) - den_w) <<< (K + 2);
            trial = in_data.lane[l].rem - delta;
            if (!trial[DW-1]) begin
                data_next.lane[l].rem  = trial;
                data_next.lane[l].acc  = in_data.lane[l].acc + ACW'(den_w <<< K);
                data_next.lane[l].q[K] = 1'b1;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### hw/rtl/vara_mix.sv
// ----------------------------------------------------------------------------
// vara_mix
// builds the matrix from the four ratios and rotates the vector
// ----------------------------------------------------------------------------
module vara_mix (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  vara_pkg::chain_t                         in_data,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [8:0][vara_pkg::ENT_W-1:0]   out_rot,
    output logic signed [2:0][vara_pkg::VEC_W-1:0]   out_vec,
    output logic                                     out_deg
);
    import vara_pkg::*;

    localparam int NST = 5;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;
    logic [NST-1:0] adv;

    // stage 1
    logic signed [ENT_W-1:0]    ct_reg;
    logic signed [31:0]         spsp_reg, cpcp_reg, cpsp_reg, stsp_reg, stcp_reg;
    logic                       deg1_reg;
    logic signed [IN_WIDTH-1:0] a1_reg, b1_reg, c1_reg;
    // stage 2
    logic signed [ENT_W-1:0]    ct2_reg;
    logic signed [47:0]         t22_reg, t23_reg, t33_reg;
    logic signed [17:0]         r21_reg, r31_reg;
    logic                       deg2_reg;
    logic signed [IN_WIDTH-1:0] a2_reg, b2_reg, c2_reg;
    // stage 3
    logic signed [8:0][ENT_W-1:0] r3_reg;
    logic                         deg3_reg;
    logic signed [IN_WIDTH-1:0]   a3_reg, b3_reg, c3_reg;
    // stage 4
    logic signed [8:0][ENT_W-1:0] r4_reg;
    logic signed [8:0][32:0]      p4_reg;
    logic                         deg4_reg;
    // stage 5
    logic signed [8:0][ENT_W-1:0] r5_reg;
    logic signed [2:0][VEC_W-1:0] y5_reg;
    logic                         deg5_reg;

    logic signed [ENT_W-1:0] cp, sp, ct, st;

    // stall chain: a stage moves when the one after it has room
    always_comb begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        adv[0] = rdy[0] && in_valid;
        for (int i = 1; i < NST; i++) begin
            adv[i] = rdy[i] && v_reg[i-1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // signed, capped ratios; phi is zero when b and c vanish
    function automatic logic signed [ENT_W-1:0] cap_q(input logic [QW-1:0] q,
                                                     input logic neg);
        logic [ENT_W-1:0] m;
        m = (q > QW'(ONE)) ? ENT_W'(ONE) : ENT_W'(q);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    always_comb begin
        if (in_data.s1 == '0) begin
            cp = ENT_W'(ONE);
            sp = '0;
        end else begin
            cp = cap_q(in_data.lane[L_CPHI].q, in_data.c[IN_WIDTH-1]);
            sp = cap_q(in_data.lane[L_SPHI].q, in_data.b[IN_WIDTH-1]);
        end
        ct = cap_q(in_data.lane[L_CTH].q, 1'b0);
        st = cap_q(in_data.lane[L_STH].q, in_data.a[IN_WIDTH-1]);
    end

    // stage 1: products of the ratios
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ct_reg   <= ct;
            spsp_reg <= 32'(sp) * 32'(sp);
            cpcp_reg <= 32'(cp) * 32'(cp);
            cpsp_reg <= 32'(cp) * 32'(sp);
            stsp_reg <= 32'(st) * 32'(sp);
            stcp_reg <= 32'(st) * 32'(cp);
            deg1_reg <= (in_data.s == '0);
            a1_reg   <= in_data.a;
            b1_reg   <= in_data.b;
            c1_reg   <= in_data.c;
        end
    end

    // stage 2: theta-weighted terms and the first-column entries
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            ct2_reg  <= ct_reg;
            t22_reg  <= 48'(ct_reg) * 48'(spsp_reg) + (48'(cpcp_reg) <<< FRAC_BITS);
            t23_reg  <= 48'(ct_reg) * 48'(cpsp_reg) - (48'(cpsp_reg) <<< FRAC_BITS);
            t33_reg  <= 48'(ct_reg) * 48'(cpcp_reg) + (48'(spsp_reg) <<< FRAC_BITS);
            r21_reg  <= 18'(rnd_shift(64'(stsp_reg), FRAC_BITS));
            r31_reg  <= 18'(rnd_shift(64'(stcp_reg), FRAC_BITS));
            deg2_reg <= deg1_reg;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
        end
    end

    // stage 3: round, saturate, identity for the all-zero vector
    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            if (deg2_reg) begin
                for (int i = 0; i < 9; i++) begin
                    r3_reg[i] <= (i == 0 || i == 4 || i == 8) ? ENT_W'(ONE) : ENT_W'(0);
                end
            end else begin
                r3_reg[0] <= clamp_ent(64'(ct2_reg));
                r3_reg[1] <= clamp_ent(-64'(r21_reg));
                r3_reg[2] <= clamp_ent(-64'(r31_reg));
                r3_reg[3] <= clamp_ent(64'(r21_reg));
                r3_reg[4] <= clamp_ent(rnd_shift(64'(t22_reg), 2 * FRAC_BITS));
                r3_reg[5] <= clamp_ent(rnd_shift(64'(t23_reg), 2 * FRAC_BITS));
                r3_reg[6] <= clamp_ent(64'(r31_reg));
                r3_reg[7] <= clamp_ent(rnd_shift(64'(t23_reg), 2 * FRAC_BITS));
                r3_reg[8] <= clamp_ent(rnd_shift(64'(t33_reg), 2 * FRAC_BITS));
            end
            deg3_reg <= deg2_reg;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            c3_reg   <= c2_reg;
        end
    end

    // stage 4: matrix times vector, one product per entry
    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            for (int i = 0; i < 3; i++) begin
                p4_reg[3*i]   <= 33'($signed(r3_reg[3*i]))   * 33'(a3_reg);
                p4_reg[3*i+1] <= 33'($signed(r3_reg[3*i+1])) * 33'(b3_reg);
                p4_reg[3*i+2] <= 33'($signed(r3_reg[3*i+2])) * 33'(c3_reg);
            end
            r4_reg   <= r3_reg;
            deg4_reg <= deg3_reg;
        end
    end

    // stage 5: row sums, rounded to integers and saturated
    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            for (int i = 0; i < 3; i++) begin
                y5_reg[i] <= clamp_vec(rnd_shift(64'($signed(p4_reg[3*i]))
                                                 + 64'($signed(p4_reg[3*i+1]))
                                                 + 64'($signed(p4_reg[3*i+2])),
                                                 FRAC_BITS));
            end
            r5_reg   <= r4_reg;
            deg5_reg <= deg4_reg;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_rot   = r5_reg;
    assign out_vec   = y5_reg;
    assign out_deg   = deg5_reg;

endmodule

### hw/rtl/vara_checker.sv
// ----------------------------------------------------------------------------
// vara_checker
// port-level checks on the result stream of the alignment rotation
// ----------------------------------------------------------------------------
`include "vector_align_rotation_3d_assert.svh"

module vara_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [183:0] m_tdata,
    input logic [0:0]   m_tuser
);
    import vara_pkg::*;

    // a stalled result stays offered
    `VARA_CHECK_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // all-zero vector gives R11 of one and a zero rotated vector
    `VARA_CHECK(a_degen, m_tvalid && m_tuser[0], m_tdata[15:0] == 16'(ONE) && m_tdata[178:128] == '0, "degenerate result not identity")

    // R12 is the negative of R21
    `VARA_CHECK(a_skew, m_tvalid, m_tdata[31:16] == 16'(-m_tdata[63:48]), "R12 and R21 not opposite")

    // cos theta lies in zero to one
    `VARA_CHECK(a_cth, m_tvalid, m_tdata[15:0] <= 16'(ONE), "R11 out of range")

endmodule

bind vector_align_rotation_3d vara_checker u_vara_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// vector_align_rotation_3d testbench
// drives 3-vectors over the input stream, predicts the rotation matrix, the
// rotated vector and the degenerate flag for each, and compares every result
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ONE_Q     = 1 << 14;
    localparam int LAT_CYC   = 40;
    localparam int MAX_CYC   = 400000;

    // first component in the lowest bits, as on s_tdata
    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] b;
        logic signed [15:0] a;
    } vec_t;

    typedef struct {
        logic [15:0] ent [8];
        logic [16:0] rv [3];
        logic        deg;
    } rot_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;    // comp_a, comp_b, comp_c
    logic         m_tvalid;
    logic         m_tready;
    logic [183:0] m_tdata;    // 8 entries, out_a, out_b, out_c, zero fill
    logic [0:0]   m_tuser;    // degenerate

    vec_t  vec_q [$];
    rot_t  rot_q [$];
    int    n_err = 0;
    int    n_res = 0;
    int    n_deg = 0;
    int    cyc;
    int    gap_cnt;
    int    stall_cnt;
    bit    hold_drain;
    bit    stim_done;

    vector_align_rotation_3d u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // round(sqrt(num/den) * ONE), capped at ONE, by digit recurrence
    function automatic longint root_q(longint unsigned num, longint unsigned den);
        longint unsigned rhs;
        longint unsigned q;
        longint unsigned t;
        longint unsigned m;
        rhs = num << 30;
        q = 0;
        for (int k = 14; k >= 0; k--) begin
            t = q | (64'd1 << k);
            m = 2 * t - 1;
            if (m * m * den <= rhs) q = t;
        end
        if (q > ONE_Q) q = ONE_Q;
        return longint'(q);
    endfunction

    function automatic longint signed_root(longint x, longint unsigned den);
        longint unsigned mag;
        longint r;
        mag = x < 0 ? -x : x;
        r = root_q(mag * mag, den);
        return x < 0 ? -r : r;
    endfunction

    // shift right, rounding to nearest with ties away from zero
    function automatic longint rshift_rnd(longint v, int sh);
        longint unsigned mag;
        mag = v < 0 ? -v : v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return v < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // expected rotation, rotated vector and flag for one input vector
    function automatic rot_t align_rotation(vec_t v);
        rot_t    e;
        longint  a, b, c, cp, sp, ct, st, acc;
        longint  r [9];
        longint unsigned s1, s;
        a = v.a;
        b = v.b;
        c = v.c;
        s1 = b * b + c * c;
        s = s1 + a * a;
        e.deg = 1'b0;
        if (s == 0) begin
            e.deg = 1'b1;
            foreach (r[i]) r[i] = 0;
            r[0] = ONE_Q;
            r[4] = ONE_Q;
            r[8] = ONE_Q;
        end else begin
            if (s1 == 0) begin
                cp = ONE_Q;
                sp = 0;
            end else begin
                cp = signed_root(c, s1);
                sp = signed_root(b, s1);
            end
            ct = root_q(s1, s);
            st = signed_root(a, s);
            r[0] = ct;
            r[3] = rshift_rnd(st * sp, 14);
            r[1] = -r[3];
            r[6] = rshift_rnd(st * cp, 14);
            r[2] = -r[6];
            r[4] = rshift_rnd(ct * sp * sp + cp * cp * ONE_Q, 28);
            r[5] = rshift_rnd(ct * cp * sp - cp * sp * ONE_Q, 28);
            r[7] = r[5];
            r[8] = rshift_rnd(ct * cp * cp + sp * sp * ONE_Q, 28);
            foreach (r[i]) r[i] = sat(r[i], -ONE_Q, ONE_Q);
        end
        for (int i = 0; i < 3; i++) begin
            acc = r[3*i] * a + r[3*i+1] * b + r[3*i+2] * c;
            e.rv[i] = 17'(sat(rshift_rnd(acc, 14), -65536, 65535));
        end
        for (int i = 0; i < 7; i++) e.ent[i] = 16'(r[i]);
        e.ent[7] = 16'(r[8]);
        return e;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(0);
            3: return 16'($urandom_range(0, 8)) - 16'sd4;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_vec(logic signed [15:0] a, logic signed [15:0] b,
                           logic signed [15:0] c);
        vec_t v;
        v.a = a;
        v.b = b;
        v.c = c;
        vec_q.push_back(v);
    endtask

    // stimulus: directed corners first, then random vectors
    initial begin
        logic signed [15:0] ext [4];
        ext = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};
        foreach (ext[i])
            foreach (ext[j])
                add_vec(ext[i], ext[j], ext[(i + j) % 4]);
        add_vec(16'sd0, 16'sd0, 16'sd0);
        add_vec(16'sd5, 16'sd0, 16'sd0);
        add_vec(-16'sd7, 16'sd0, 16'sd0);
        add_vec(16'sd0, 16'sd3, 16'sd4);
        add_vec(16'sh8000, 16'sh8000, 16'sh8000);
        add_vec(16'sh7fff, 16'sh7fff, 16'sh7fff);
        add_vec(16'sd1, 16'sd1, 16'sd1);
        add_vec(16'sh5555, 16'shaaaa, 16'sh5555);
        add_vec(16'shaaaa, 16'sh5555, 16'shaaaa);
        for (int i = 0; i < 1500; i++) begin
            if ($urandom_range(0, 9) == 0)
                add_vec(rand_comp(), 16'sd0, 16'sd0);
            else
                add_vec(rand_comp(), rand_comp(), rand_comp());
        end
    end

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            gap_cnt    <= 0;
            stim_done  <= 1'b0;
            hold_drain <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                rot_q.push_back(align_rotation(vec_t'(s_tdata)));
            // pause ends once everything in flight has come back
            if (hold_drain && rot_q.size() == 0 && !s_tvalid)
                hold_drain <= 1'b0;
            if (!s_tvalid || s_tready) begin
                if (hold_drain && (rot_q.size() != 0 || (s_tvalid && s_tready))) begin
                    s_tvalid <= 1'b0;
                end else if (gap_cnt > 0) begin
                    gap_cnt  <= gap_cnt - 1;
                    s_tvalid <= 1'b0;
                end else if (vec_q.size() != 0) begin
                    // one pause until everything in flight has drained
                    if (vec_q.size() == 700 && !hold_drain) begin
                        hold_drain <= 1'b1;
                        s_tvalid   <= 1'b0;
                    end else begin
                        s_tdata  <= {vec_q[0].c, vec_q[0].b, vec_q[0].a};
                        void'(vec_q.pop_front());
                        s_tvalid <= 1'b1;
                        if (cyc % 2000 > 1500 && $urandom_range(0, 2) == 0)
                            gap_cnt <= ($urandom_range(0, 9) == 0) ?
                                       $urandom_range(10, 40) : $urandom_range(0, 3);
                    end
                end else begin
                    s_tvalid  <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // result monitor and ready generator
    always @(posedge aclk) begin
        rot_t got;
        rot_t e;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                for (int i = 0; i < 8; i++) got.ent[i] = m_tdata[16*i +: 16];
                for (int i = 0; i < 3; i++) got.rv[i] = m_tdata[128 + 17*i +: 17];
                got.deg = m_tuser[0];
                if (rot_q.size() == 0) begin
                    $display("%0t: result with none expected, data %h", $time, m_tdata);
                    n_err++;
                end else begin
                    e = rot_q.pop_front();
                    n_res++;
                    if (e.deg) n_deg++;
                    for (int i = 0; i < 8; i++)
                        if (got.ent[i] !== e.ent[i]) begin
                            $display("%0t: entry %0d expected %h actual %h",
                                     $time, i, e.ent[i], got.ent[i]);
                            n_err++;
                        end
                    for (int i = 0; i < 3; i++)
                        if (got.rv[i] !== e.rv[i]) begin
                            $display("%0t: rotated comp %0d expected %h actual %h",
                                     $time, i, e.rv[i], got.rv[i]);
                            n_err++;
                        end
                    if (got.deg !== e.deg) begin
                        $display("%0t: degenerate expected %b actual %b",
                                 $time, e.deg, got.deg);
                        n_err++;
                    end
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                m_tready  <= 1'b0;
            end else if (cyc % 1700 > 1200 && $urandom_range(0, 3) == 0) begin
                stall_cnt <= ($urandom_range(0, 9) == 0) ?
                             $urandom_range(10, 50) : $urandom_range(0, 3);
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // reset, end of run and timeout
    initial begin
        cyc        = 0;
        aresetn    = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(stim_done && rot_q.size() == 0) && cyc < MAX_CYC) begin
            @(posedge aclk);
            cyc++;
        end
        if (cyc >= MAX_CYC) begin
            $display("vector_align_rotation_3d test failed");
            $finish;
        end else begin
            repeat (LAT_CYC) @(posedge aclk);
            $display("checked %0d rotations, %0d of them degenerate, with random gaps",
                     n_res, n_deg);
            if (n_err == 0)
                $display("vector_align_rotation_3d test passed");
            else
                $display("vector_align_rotation_3d test failed");
            $finish;
        end
    end

endmodule

### vector_align_rotation_3d.f
+incdir+hw/rtl
hw/rtl/vara_pkg.sv
hw/rtl/vara_cell.sv
hw/rtl/vara_mix.sv
hw/rtl/vector_align_rotation_3d.sv
hw/rtl/vara_checker.sv
tb/tb_top.sv
